// File: hdl/owbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int REG_WIDTH     = 16;
   localparam int NUM_REGS      = 8;
   localparam int REG_IDX_WIDTH = 3;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_RESET = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [REG_IDX_WIDTH-1:0] REG_RESET_LOW    = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_PRESENCE_SMP = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_RESET_TAIL   = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_WRITE_LEAD   = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_SLOT         = 3'd4;
   localparam logic [REG_IDX_WIDTH-1:0] REG_READ_LOW     = 3'd5;
   localparam logic [REG_IDX_WIDTH-1:0] REG_READ_SAMPLE  = 3'd6;
   localparam logic [REG_IDX_WIDTH-1:0] REG_RECOVERY     = 3'd7;

   localparam logic [REG_WIDTH-1:0] RST_RESET_LOW    = 16'd480;
   localparam logic [REG_WIDTH-1:0] RST_PRESENCE_SMP = 16'd70;
   localparam logic [REG_WIDTH-1:0] RST_RESET_TAIL   = 16'd410;
   localparam logic [REG_WIDTH-1:0] RST_WRITE_LEAD   = 16'd6;
   localparam logic [REG_WIDTH-1:0] RST_SLOT         = 16'd60;
   localparam logic [REG_WIDTH-1:0] RST_READ_LOW     = 16'd6;
   localparam logic [REG_WIDTH-1:0] RST_READ_SAMPLE  = 16'd9;
   localparam logic [REG_WIDTH-1:0] RST_RECOVERY     = 16'd10;

   localparam logic [BITS_PER_BYTE-1:0] LSB_MASK = 8'h01;
   localparam logic [BITS_PER_BYTE-1:0] MSB_BIT  = 8'h80;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_RST_LOW  = 8'b0000_0010,
      PH_RST_WAIT = 8'b0000_0100,
      PH_RST_TAIL = 8'b0000_1000,
      PH_WR_SLOT  = 8'b0001_0000,
      PH_WR_REC   = 8'b0010_0000,
      PH_RD_SLOT  = 8'b0100_0000,
      PH_RD_REC   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] reset_low_ticks;
      logic [REG_WIDTH-1:0] presence_sample_ticks;
      logic [REG_WIDTH-1:0] reset_tail_ticks;
      logic [REG_WIDTH-1:0] write_lead_ticks;
      logic [REG_WIDTH-1:0] slot_ticks;
      logic [REG_WIDTH-1:0] read_low_ticks;
      logic [REG_WIDTH-1:0] read_sample_ticks;
      logic [REG_WIDTH-1:0] recovery_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic [BITS_PER_BYTE-1:0] tx_byte;
      logic                     line_level;
   } tick_type;

   typedef struct packed {
      logic                     drive_low;
      logic                     busy_res;
      logic                     done_res;
      logic                     presence;
      logic [BITS_PER_BYTE-1:0] rx_byte;
   } result_type;

endpackage
`default_nettype wire

// File: hdl/owbm_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_csr
// Timing registers of the bus master, written through a plain write port.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [owbm_pkg::REG_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [owbm_pkg::REG_WIDTH-1:0]        csr_wdata,
   output owbm_pkg::cfg_type                          cfg
);

   owbm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            owbm_pkg::REG_RESET_LOW:    cfg_in.reset_low_ticks       = csr_wdata;
            owbm_pkg::REG_PRESENCE_SMP: cfg_in.presence_sample_ticks = csr_wdata;
            owbm_pkg::REG_RESET_TAIL:   cfg_in.reset_tail_ticks      = csr_wdata;
            owbm_pkg::REG_WRITE_LEAD:   cfg_in.write_lead_ticks      = csr_wdata;
            owbm_pkg::REG_SLOT:         cfg_in.slot_ticks            = csr_wdata;
            owbm_pkg::REG_READ_LOW:     cfg_in.read_low_ticks        = csr_wdata;
            owbm_pkg::REG_READ_SAMPLE:  cfg_in.read_sample_ticks     = csr_wdata;
            owbm_pkg::REG_RECOVERY:     cfg_in.recovery_ticks        = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= owbm_pkg::RST_RESET_LOW;
         cfg_ff.presence_sample_ticks <= owbm_pkg::RST_PRESENCE_SMP;
         cfg_ff.reset_tail_ticks      <= owbm_pkg::RST_RESET_TAIL;
         cfg_ff.write_lead_ticks      <= owbm_pkg::RST_WRITE_LEAD;
         cfg_ff.slot_ticks            <= owbm_pkg::RST_SLOT;
         cfg_ff.read_low_ticks        <= owbm_pkg::RST_READ_LOW;
         cfg_ff.read_sample_ticks     <= owbm_pkg::RST_READ_SAMPLE;
         cfg_ff.recovery_ticks        <= owbm_pkg::RST_RECOVERY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: hdl/owbm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_core
// Bus phase sequencer: advances phase, tick, bit and shift state one tick
// per step and forms the result word for that tick.
// ----------------------------------------------------------------------------
module owbm_core #(
   parameter int COUNTER_WIDTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  owbm_pkg::tick_type tick,
   input  owbm_pkg::cfg_type  cfg,
   output owbm_pkg::result_type res
);

   localparam int W  = COUNTER_WIDTH;
   localparam int CW = (COUNTER_WIDTH > owbm_pkg::REG_WIDTH) ? COUNTER_WIDTH
                                                             : owbm_pkg::REG_WIDTH;
   localparam int BW = $clog2(owbm_pkg::BITS_PER_BYTE);
   localparam logic [BW-1:0] LAST_BIT = BW'(owbm_pkg::BITS_PER_BYTE - 1);

   owbm_pkg::phase_type phase_ff, phase_in;
   logic [W-1:0]  tick_ff, tick_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [owbm_pkg::BITS_PER_BYTE-1:0] shift_ff, shift_in;
   logic          pres_ff, pres_in;
   logic [owbm_pkg::BITS_PER_BYTE-1:0] last_ff, last_in;

   function automatic logic [W-1:0] last_tick(input logic [owbm_pkg::REG_WIDTH-1:0] v);
      logic [owbm_pkg::REG_WIDTH-1:0] e;
      logic [CW-1:0] x;
      e = (v == '0) ? owbm_pkg::REG_WIDTH'(1) : v;
      x = CW'(e) - CW'(1);
      return x[W-1:0];
   endfunction

   owbm_pkg::phase_type ph, nxt;
   logic [W-1:0]  t, endt;
   logic [CW-1:0] lead, lowp, smp;
   logic          drive, done, busy;

   always_comb begin
      ph       = phase_ff;
      t        = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      last_in  = last_ff;
      drive    = 1'b0;
      done     = 1'b0;
      endt     = '0;
      nxt      = owbm_pkg::PH_IDLE;
      lead     = CW'(cfg.write_lead_ticks == '0 ? owbm_pkg::REG_WIDTH'(1)
                                                : cfg.write_lead_ticks);
      lowp     = CW'(cfg.read_low_ticks == '0 ? owbm_pkg::REG_WIDTH'(1)
                                              : cfg.read_low_ticks);
      smp      = CW'(cfg.read_sample_ticks);

      if (phase_ff == owbm_pkg::PH_IDLE && tick.mode != owbm_pkg::MODE_TICK) begin
         t      = '0;
         bit_in = '0;
         unique case (tick.mode)
            owbm_pkg::MODE_RESET: ph = owbm_pkg::PH_RST_LOW;
            owbm_pkg::MODE_WRITE: begin
               ph       = owbm_pkg::PH_WR_SLOT;
               shift_in = tick.tx_byte;
            end
            default: begin
               ph       = owbm_pkg::PH_RD_SLOT;
               shift_in = '0;
            end
         endcase
      end
      busy = (ph != owbm_pkg::PH_IDLE);

      unique case (ph)
         owbm_pkg::PH_RST_LOW: begin
            drive = 1'b1;
            endt  = last_tick(cfg.reset_low_ticks);
            nxt   = owbm_pkg::PH_RST_WAIT;
         end
         owbm_pkg::PH_RST_WAIT: begin
            endt = last_tick(cfg.presence_sample_ticks);
            if (t == endt) pres_in = ~tick.line_level;
            nxt  = owbm_pkg::PH_RST_TAIL;
         end
         owbm_pkg::PH_RST_TAIL: begin
            endt = last_tick(cfg.reset_tail_ticks);
            nxt  = owbm_pkg::PH_IDLE;
         end
         owbm_pkg::PH_WR_SLOT: begin
            endt  = last_tick(cfg.slot_ticks);
            drive = (CW'(t) < lead) || ((shift_in & owbm_pkg::LSB_MASK) == '0);
            nxt   = owbm_pkg::PH_WR_REC;
         end
         owbm_pkg::PH_RD_SLOT: begin
            endt = last_tick(cfg.slot_ticks);
            if (smp > CW'(endt)) smp = CW'(endt);
            drive = (CW'(t) < lowp);
            if (t == smp[W-1:0])
               shift_in = (shift_in >> 1) | (tick.line_level ? owbm_pkg::MSB_BIT : '0);
            nxt  = owbm_pkg::PH_RD_REC;
         end
         owbm_pkg::PH_WR_REC, owbm_pkg::PH_RD_REC: begin
            endt = last_tick(cfg.recovery_ticks);
         end
         default: ;
      endcase

      phase_in = ph;
      tick_in  = t;
      if (ph != owbm_pkg::PH_IDLE) begin
         if (t == endt) begin
            tick_in = '0;
            if (ph == owbm_pkg::PH_WR_SLOT) shift_in = shift_in >> 1;
            if (ph == owbm_pkg::PH_WR_REC || ph == owbm_pkg::PH_RD_REC) begin
               if (bit_in == LAST_BIT) begin
                  if (ph == owbm_pkg::PH_RD_REC) last_in = shift_in;
                  nxt = owbm_pkg::PH_IDLE;
               end else begin
                  bit_in = bit_in + BW'(1);
                  nxt    = (ph == owbm_pkg::PH_WR_REC) ? owbm_pkg::PH_WR_SLOT
                                                       : owbm_pkg::PH_RD_SLOT;
               end
            end
            done     = (nxt == owbm_pkg::PH_IDLE);
            phase_in = nxt;
         end else begin
            tick_in = t + W'(1);
         end
      end

      res.drive_low = drive;
      res.busy_res  = busy;
      res.done_res  = done;
      res.presence  = pres_in;
      res.rx_byte   = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owbm_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         last_ff  <= last_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) $onehot(phase_ff))
      else $error("phase register lost its one-hot code");
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("sequencer moved without a step");

endmodule
`default_nettype wire

// File: hdl/one_wire_bus_master_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Single-wire bus master timed in ticks: bus reset with presence detect,
// byte write and byte read, LSB first.
// ----------------------------------------------------------------------------
//  channel  direction  words            handshake
//  req_     in         one tick         tvalid / tready
//  rsp_     out        one tick result  tvalid / tready
//  csr_     in         register write   csr_we, no wait
//
//  One word in, one word out, one tick per clock sustained while rsp_tready stays high.
//  Each word passes the input register, then the sequencer and result register.
//  The sequencer steps only when the result register is free or being taken.
//  A stalled rsp_ side holds the input register; req_tready drops once both fill.
//  Synchronous reset restores the register defaults and an idle bus.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit #(
   parameter int COUNTER_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [1:0] mode
   input  wire logic [1:0]  req_tuser,
   // [7:0] tx_byte, [8] line_level, [15:9] zero
   input  wire logic [15:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] rx_byte,
   // [15:12] zero
   output      logic [15:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [owbm_pkg::REG_IDX_WIDTH-1:0] csr_index,
   input  wire logic [owbm_pkg::REG_WIDTH-1:0]     csr_wdata
);

   owbm_pkg::cfg_type    cfg;
   owbm_pkg::tick_type   in_data_ff, in_data_in;
   owbm_pkg::result_type out_res_ff, step_res;
   logic in_vld_ff, in_vld_in;
   logic out_vld_ff, out_vld_in;
   logic advance, step, req_take;

   assign advance    = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || step;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_data_in.mode       = req_tuser;
      in_data_in.tx_byte    = req_tdata[7:0];
      in_data_in.line_level = req_tdata[8];
      in_vld_in  = req_take ? 1'b1 : (step ? 1'b0 : in_vld_ff);
      out_vld_in = step ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
   end

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owbm_core #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .tick  (in_data_ff),
      .cfg   (cfg),
      .res   (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_data_ff <= in_data_in;
      if (step)     out_res_ff <= step_res;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0, out_res_ff.rx_byte, out_res_ff.presence,
                        out_res_ff.done_res, out_res_ff.busy_res, out_res_ff.drive_low};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1])
      else $error("done without busy");
   assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_tready)
      else $error("empty input register refused a word");
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !out_vld_ff |=> out_vld_ff)
      else $error("pending word did not reach the result register");

endmodule
`default_nettype wire
